// ===== src/rcb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcb_pkg: shared types and constants of the 3x3 RGB convolution block
// Field widths, register codes, reset values and the per-pixel side-band
// record that travels with each word through the filter pipeline.
// ----------------------------------------------------------------------------
package rcb_pkg;

	// Default line length bound (storage depth of the line memory)
	localparam int MAX_WIDTH_DEF = 2048;

	// Field widths
	localparam int CH_W        = 8;
	localparam int CH_N        = 3;
	localparam int PIX_W       = CH_W * CH_N;
	localparam int COL_W       = 11;
	localparam int ROW_W       = 16;
	localparam int WIDTH_REG_W = 12;
	localparam int COEF_W      = 16;
	localparam int COEF_ROW_W  = 3 * COEF_W;
	localparam int CFG_IDX_W   = 3;

	// Arithmetic widths: 9-bit signed pixel times 16-bit signed coefficient
	localparam int PROD_W   = 25;
	localparam int ROWSUM_W = 27;
	localparam int SUM_W    = 29;
	localparam int FRAC_W   = 12;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_TOP     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_MID     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_BOTTOM  = 3'd4;

	// Register reset values; coefficients are 455 (about 1/9 in Q3.12)
	localparam logic [WIDTH_REG_W-1:0] WIDTH_RESET  = 12'd512;
	localparam logic [ROW_W-1:0]       HEIGHT_RESET = 16'd512;
	localparam logic [COEF_ROW_W-1:0]  COEF_RESET   = 48'h01C7_01C7_01C7;

	// Result slots of one pixel, emitted from the lowest set bit up
	localparam int SLOT_N      = 3;
	localparam int SLOT_MAIN   = 0; // filtered window center or left border copy
	localparam int SLOT_BORDER = 1; // right border copy of the row above
	localparam int SLOT_OWN    = 2; // the pixel itself (top or bottom row)

	typedef logic [PIX_W-1:0] pix_t;

	// 3x3 window, [row top..bottom][col left..right]
	typedef logic [2:0][2:0][PIX_W-1:0] win_t;

	// Three coefficient rows, top..bottom
	typedef logic [2:0][COEF_ROW_W-1:0] coef_t;

	// Side-band record of one accepted pixel
	typedef struct packed {
		logic [COL_W-1:0]  col;      // column of the pixel
		logic [COL_W-1:0]  col0;     // column of the main-slot result
		logic [ROW_W-1:0]  row;      // row of the pixel
		logic [ROW_W-1:0]  row_m1;   // row above
		pix_t              px;       // the pixel itself
		pix_t              above;    // same column, row above
		pix_t              left;     // left border pixel of the row above
		logic              use_left; // main slot is a copy, not a filter result
		logic [SLOT_N-1:0] slots;    // results this pixel causes
	} meta_t;

endpackage

// ===== src/rcb_line_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcb_line_mem: simple dual-port line memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module rcb_line_mem #(
	parameter int DEPTH = rcb_pkg::MAX_WIDTH_DEF,
	parameter int WIDTH = 2 * rcb_pkg::PIX_W
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port, holds while not enabled
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ===== src/rcb_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcb_front: raster position, line memory access and 3x3 window
// Reads both rows above at the accepted column, writes the shifted rows back
// as the word leaves stage 1 and shifts the window. Flags the results each pixel causes.
// ----------------------------------------------------------------------------
module rcb_front #(
	parameter int MAX_WIDTH = rcb_pkg::MAX_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [rcb_pkg::WIDTH_REG_W-1:0] image_width,
	input  logic [rcb_pkg::ROW_W-1:0]       image_height,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  rcb_pkg::pix_t                   in_pix,
	output logic                            out_valid,
	input  logic                            out_ready,
	output rcb_pkg::meta_t                  out_meta,
	output rcb_pkg::win_t                   out_win
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int LW = (CW + 1 > rcb_pkg::WIDTH_REG_W) ? CW + 1 : rcb_pkg::WIDTH_REG_W;
	localparam int PW = rcb_pkg::PIX_W;
	localparam int RW = rcb_pkg::ROW_W;

	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;

	logic [LW-1:0] w_ext, w_max, w_eff, w_m1;
	logic [RW-1:0] h_eff, h_m1;
	logic          row_end, last_row, row_ge2;
	logic          accept, s1_go, r2;

	logic           v1_q, v2_q;
	logic [CW-1:0]  col_s1;
	rcb_pkg::pix_t  px_s1;
	rcb_pkg::meta_t meta_c, meta_s1, meta_n, meta_s2;
	rcb_pkg::win_t  win_q;
	logic [2*PW-1:0] rd_data, wr_data;

	// Clamp the frame size to the supported range
	always_comb begin
		w_ext = LW'(image_width);
		w_max = LW'(MAX_WIDTH);
		if (w_ext < LW'(3)) begin
			w_eff = LW'(3);
		end else if (w_ext > w_max) begin
			w_eff = w_max;
		end else begin
			w_eff = w_ext;
		end
		w_m1  = w_eff - LW'(1);
		h_eff = (image_height < RW'(3)) ? RW'(3) : image_height;
		h_m1  = h_eff - RW'(1);
	end

	assign row_end  = LW'(col_q) >= w_m1;
	assign last_row = row_q >= h_m1;
	assign row_ge2  = row_q >= RW'(2);

	// Handshake between the stages
	assign r2       = !v2_q || out_ready;
	assign s1_go    = v1_q && r2;
	assign in_ready = !v1_q || r2;
	assign accept   = in_valid && in_ready;

	// Classify the results of the pixel at the current position
	always_comb begin
		meta_c          = '0;
		meta_c.col      = rcb_pkg::COL_W'(col_q);
		meta_c.col0     = (col_q == CW'(1)) ? '0 : rcb_pkg::COL_W'(col_q - CW'(1));
		meta_c.row      = row_q;
		meta_c.row_m1   = row_q - RW'(1);
		meta_c.px       = in_pix;
		meta_c.use_left = col_q == CW'(1);
		meta_c.slots[rcb_pkg::SLOT_MAIN]   = row_ge2 && (col_q != '0);
		meta_c.slots[rcb_pkg::SLOT_BORDER] = row_ge2 && row_end;
		meta_c.slots[rcb_pkg::SLOT_OWN]    = (row_q == '0) || (row_ge2 && last_row);
	end

	// Advance the raster position on each accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (row_end) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + RW'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	// Line memory: entry holds {row r-2, row r-1} of one column. Consecutive
	// words never share a column, so a write never meets a read of its entry.
	assign wr_data = {rd_data[PW-1:0], px_s1};

	rcb_line_mem #(
		.DEPTH (MAX_WIDTH),
		.WIDTH (2 * PW)
	) u_line_mem (
		.clk     (clk),
		.wr_en   (s1_go),
		.wr_addr (col_s1),
		.wr_data (wr_data),
		.rd_en   (accept),
		.rd_addr (col_q),
		.rd_data (rd_data)
	);

	// Stage 1: wait for the line memory read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
		end else if (in_ready) begin
			v1_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			col_s1  <= col_q;
			px_s1   <= in_pix;
			meta_s1 <= meta_c;
		end
	end

	// Stage 2: shift the window, attach the copies taken from the rows above
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v2_q  <= 1'b0;
			win_q <= '0;
		end else begin
			if (r2) begin
				v2_q <= v1_q;
			end
			if (s1_go) begin
				for (int i = 0; i < 3; i++) begin
					win_q[i][0] <= win_q[i][1];
					win_q[i][1] <= win_q[i][2];
				end
				win_q[0][2] <= rd_data[2*PW-1:PW];
				win_q[1][2] <= rd_data[PW-1:0];
				win_q[2][2] <= px_s1;
			end
		end
	end

	// Merge the row-above pixel and the left border pixel into the record
	always_comb begin
		meta_n       = meta_s1;
		meta_n.above = rd_data[PW-1:0];
		meta_n.left  = win_q[1][2];
	end

	always_ff @(posedge clk) begin
		if (s1_go) begin
			meta_s2 <= meta_n;
		end
	end

	assign out_valid = v2_q;
	assign out_meta  = meta_s2;
	assign out_win   = win_q;

endmodule

// ===== src/rcb_filter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcb_filter: 3x3 weighted sum per channel
// Three stages: products, row sums, total with shift and saturation to 0..255.
// The side-band record travels alongside.
// ----------------------------------------------------------------------------
module rcb_filter (
	input  logic           clk,
	input  logic           arst_n,
	input  rcb_pkg::coef_t coef,
	input  logic           in_valid,
	output logic           in_ready,
	input  rcb_pkg::meta_t in_meta,
	input  rcb_pkg::win_t  in_win,
	output logic           out_valid,
	input  logic           out_ready,
	output rcb_pkg::meta_t out_meta,
	output rcb_pkg::pix_t  out_pix
);

	localparam int CHW = rcb_pkg::CH_W;
	localparam int CN  = rcb_pkg::CH_N;
	localparam int KW  = rcb_pkg::COEF_W;
	localparam int PRW = rcb_pkg::PROD_W;
	localparam int RSW = rcb_pkg::ROWSUM_W;
	localparam int SW  = rcb_pkg::SUM_W;
	localparam int FW  = rcb_pkg::FRAC_W;

	logic v3_q, v4_q, v5_q;
	logic r3, r4, r5;

	logic signed [PRW-1:0] prod_c  [CN][3][3];
	logic signed [PRW-1:0] prod_s3 [CN][3][3];
	logic signed [RSW-1:0] rsum_c  [CN][3];
	logic signed [RSW-1:0] rsum_s4 [CN][3];
	logic signed [SW-1:0]  total_c [CN];
	rcb_pkg::pix_t  sat_c, pix_s5;
	rcb_pkg::meta_t meta_s3, meta_s4, meta_s5;

	// Stage handshake
	assign r5       = !v5_q || out_ready;
	assign r4       = !v4_q || r5;
	assign r3       = !v3_q || r4;
	assign in_ready = r3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v3_q <= 1'b0;
			v4_q <= 1'b0;
			v5_q <= 1'b0;
		end else begin
			if (r3) v3_q <= in_valid;
			if (r4) v4_q <= v3_q;
			if (r5) v5_q <= v4_q;
		end
	end

	// Products: unsigned pixel channel times signed coefficient
	always_comb begin
		for (int ch = 0; ch < CN; ch++) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					prod_c[ch][i][j] = $signed({1'b0, in_win[i][j][CHW*ch +: CHW]})
						* $signed(coef[i][KW*j +: KW]);
				end
			end
		end
	end

	// Row sums
	always_comb begin
		for (int ch = 0; ch < CN; ch++) begin
			for (int i = 0; i < 3; i++) begin
				rsum_c[ch][i] = RSW'(prod_s3[ch][i][0]) + RSW'(prod_s3[ch][i][1])
					+ RSW'(prod_s3[ch][i][2]);
			end
		end
	end

	// Total, drop the fraction, clamp to 0..255
	always_comb begin
		for (int ch = 0; ch < CN; ch++) begin
			total_c[ch] = SW'(rsum_s4[ch][0]) + SW'(rsum_s4[ch][1]) + SW'(rsum_s4[ch][2]);
			if (total_c[ch][SW-1]) begin
				sat_c[CHW*ch +: CHW] = '0;
			end else if (|total_c[ch][SW-2:FW+CHW]) begin
				sat_c[CHW*ch +: CHW] = '1;
			end else begin
				sat_c[CHW*ch +: CHW] = total_c[ch][FW +: CHW];
			end
		end
	end

	// Pipeline registers
	always_ff @(posedge clk) begin
		if (r3 && in_valid) begin
			prod_s3 <= prod_c;
			meta_s3 <= in_meta;
		end
		if (r4 && v3_q) begin
			rsum_s4 <= rsum_c;
			meta_s4 <= meta_s3;
		end
		if (r5 && v4_q) begin
			pix_s5  <= sat_c;
			meta_s5 <= meta_s4;
		end
	end

	assign out_valid = v5_q;
	assign out_meta  = meta_s5;
	assign out_pix   = pix_s5;

endmodule

// ===== src/rcb_emit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcb_emit: result sequencer and output register
// Holds the results of one pixel and hands them out one word per cycle while
// the output register is free, lowest slot first, marking the final one. Takes
// the next pixel in the cycle its last result moves to the output register.
// ----------------------------------------------------------------------------
module rcb_emit (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  rcb_pkg::meta_t            in_meta,
	input  rcb_pkg::pix_t             in_pix,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [rcb_pkg::COL_W-1:0] out_col,
	output logic [rcb_pkg::ROW_W-1:0] out_row,
	output rcb_pkg::pix_t             out_pix,
	output logic                      out_last
);

	localparam int SN = rcb_pkg::SLOT_N;

	logic [SN-1:0]  mask_q, sel, rest;
	rcb_pkg::meta_t meta_q;
	rcb_pkg::pix_t  filt_q;
	logic           ov_q, out_free, load, emit;

	logic [rcb_pkg::COL_W-1:0] col_c;
	logic [rcb_pkg::ROW_W-1:0] row_c;
	rcb_pkg::pix_t             pix_c;

	assign out_free = !ov_q || out_ready;
	assign emit     = out_free && (mask_q != '0);
	assign load     = (mask_q == '0) || (out_free && $onehot(mask_q));
	assign in_ready = load;

	// Pick the lowest pending slot
	assign sel  = mask_q & (~mask_q + SN'(1));
	assign rest = mask_q & ~sel;

	always_comb begin
		if (mask_q[rcb_pkg::SLOT_MAIN]) begin
			col_c = meta_q.col0;
			row_c = meta_q.row_m1;
			pix_c = meta_q.use_left ? meta_q.left : filt_q;
		end else if (mask_q[rcb_pkg::SLOT_BORDER]) begin
			col_c = meta_q.col;
			row_c = meta_q.row_m1;
			pix_c = meta_q.above;
		end else begin
			col_c = meta_q.col;
			row_c = meta_q.row;
			pix_c = meta_q.px;
		end
	end

	// Pending slots and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
			ov_q   <= 1'b0;
		end else begin
			if (load) begin
				mask_q <= in_valid ? in_meta.slots : '0;
			end else if (emit) begin
				mask_q <= rest;
			end
			if (emit) begin
				ov_q <= 1'b1;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	// Hold the pixel record and the output word
	always_ff @(posedge clk) begin
		if (load && in_valid) begin
			meta_q <= in_meta;
			filt_q <= in_pix;
		end
		if (emit) begin
			out_col  <= col_c;
			out_row  <= row_c;
			out_pix  <= pix_c;
			out_last <= rest == '0;
		end
	end

	assign out_valid = ov_q;

endmodule

// ===== src/rgb_conv3x3_border_copy.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_conv3x3_border_copy: 3x3 RGB convolution with border copy
// Raster pixels in, filtered interior pixels and copied border pixels out,
// each result word tagged with its column and row.
//
//   channel  dir  handshake                      content
//   s_axis   in   s_axis_tvalid / s_axis_tready  one raster pixel
//   m_axis   out  m_axis_tvalid / m_axis_tready  one result pixel, tlast ends
//                                                the results of one input
//   cfg      in   cfg_valid / cfg_ready          register index and data
//
// One input word per cycle while each word causes at most one result and the
// output is not stalled; a word with two or three results (row ends, the last row)
// holds the input while the single output register hands out its extra results.
// From input to first result a word passes these registers in order: line memory read, window,
// product, row sum, total, result sequencer, output register.
// Reset clears position and window, presets the configuration; the line memory is not
// cleared and needs no pass, as rows above are written before they are read.
// A stalled output backs up the pipeline stage by stage; cfg_ready is always 1.
// ----------------------------------------------------------------------------
module rgb_conv3x3_border_copy #(
	parameter int MAX_WIDTH = rcb_pkg::MAX_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// pixel in
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [23:0]                   s_axis_tdata,  // pixel_red, pixel_green, pixel_blue
	// result out
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [55:0]                   m_axis_tdata,  // out_column, out_row, out_red,
	                                                     // out_green, out_blue, zero fill
	output logic                          m_axis_tlast,  // last_of_run
	// register write
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [rcb_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rcb_pkg::COEF_ROW_W-1:0] cfg_data
);

	localparam int CHW = rcb_pkg::CH_W;

	logic [rcb_pkg::WIDTH_REG_W-1:0] image_width_q;
	logic [rcb_pkg::ROW_W-1:0]       image_height_q;
	rcb_pkg::coef_t                  coef_q;

	rcb_pkg::pix_t  in_pix;
	logic           f_valid, f_ready, k_valid, k_ready;
	rcb_pkg::meta_t f_meta, k_meta;
	rcb_pkg::win_t  f_win;
	rcb_pkg::pix_t  k_pix, o_pix;
	logic [rcb_pkg::COL_W-1:0] o_col;
	logic [rcb_pkg::ROW_W-1:0] o_row;

	// Register writes, unknown indexes dropped
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= rcb_pkg::WIDTH_RESET;
			image_height_q <= rcb_pkg::HEIGHT_RESET;
			coef_q         <= {3{rcb_pkg::COEF_RESET}};
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				rcb_pkg::REG_IMAGE_WIDTH:  image_width_q  <= cfg_data[rcb_pkg::WIDTH_REG_W-1:0];
				rcb_pkg::REG_IMAGE_HEIGHT: image_height_q <= cfg_data[rcb_pkg::ROW_W-1:0];
				rcb_pkg::REG_COEF_TOP:     coef_q[0]      <= cfg_data;
				rcb_pkg::REG_COEF_MID:     coef_q[1]      <= cfg_data;
				rcb_pkg::REG_COEF_BOTTOM:  coef_q[2]      <= cfg_data;
				default: ;
			endcase
		end
	end

	// Internal pixel order: red in the top byte
	assign in_pix = {s_axis_tdata[CHW-1:0], s_axis_tdata[2*CHW-1:CHW],
		s_axis_tdata[3*CHW-1:2*CHW]};

	rcb_front #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.image_width  (image_width_q),
		.image_height (image_height_q),
		.in_valid     (s_axis_tvalid),
		.in_ready     (s_axis_tready),
		.in_pix       (in_pix),
		.out_valid    (f_valid),
		.out_ready    (f_ready),
		.out_meta     (f_meta),
		.out_win      (f_win)
	);

	rcb_filter u_filter (
		.clk       (clk),
		.arst_n    (arst_n),
		.coef      (coef_q),
		.in_valid  (f_valid),
		.in_ready  (f_ready),
		.in_meta   (f_meta),
		.in_win    (f_win),
		.out_valid (k_valid),
		.out_ready (k_ready),
		.out_meta  (k_meta),
		.out_pix   (k_pix)
	);

	rcb_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (k_valid),
		.in_ready  (k_ready),
		.in_meta   (k_meta),
		.in_pix    (k_pix),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_col   (o_col),
		.out_row   (o_row),
		.out_pix   (o_pix),
		.out_last  (m_axis_tlast)
	);

	// Pack the result word
	assign m_axis_tdata = {5'b0, o_pix[CHW-1:0], o_pix[2*CHW-1:CHW], o_pix[3*CHW-1:2*CHW],
		o_row, o_col};

endmodule
